/* rtl/core/bad_pkg.sv */
`default_nettype none
package bad_pkg;

	localparam int BLOCK_COLS_DEF = 10;
	localparam int BLOCK_ROWS_DEF = 20;
	localparam int MAX_WIDTH_DEF  = 1280;

	localparam int PIX_W  = 8;
	localparam int FW_W   = 11;
	localparam int FH_W   = 10;
	localparam int CHAR_W = 7;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 10'd480;

	// register index, taken from paddr[2]
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
	localparam logic [CHAR_W-1:0] CHAR_NUL     = 7'd0;

	// highest ramp index
	localparam int RAMP_TOP = 9;

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int LVL_W    = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic in_range;
		logic blk_done;
		logic has_nl;
		logic frame_end;
		logic side;
	} ctl_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              has_blk;
		logic              has_nl;
		logic              has_eof;
		logic              side;
	} rec_t;

	// smallest block sum that gives ramp index k: area * ceil(255k/9)
	function automatic int level_threshold(input int k, input int area);
		return area * ((255 * k + 8) / 9);
	endfunction

	function automatic logic [CHAR_W-1:0] ramp_char(input logic [3:0] idx);
		logic [CHAR_W-1:0] c;
		case (idx)
			4'd0: c = 7'd32;   // ' '
			4'd1: c = 7'd46;   // '.'
			4'd2: c = 7'd58;   // ':'
			4'd3: c = 7'd45;   // '-'
			4'd4: c = 7'd61;   // '='
			4'd5: c = 7'd43;   // '+'
			4'd6: c = 7'd42;   // '*'
			4'd7: c = 7'd35;   // '#'
			4'd8: c = 7'd37;   // '%'
			default: c = 7'd64; // '@', index limited to top
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/bad_acc_ram.sv */
`default_nettype none
module bad_acc_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/bad_accum.sv */
`default_nettype none
module bad_accum #(
	parameter int BLOCK_AREA = 200,
	parameter int DEPTH      = 128,
	parameter int AW         = 7,
	parameter int SUM_W      = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [AW-1:0]              in_addr,
	input  wire logic [bad_pkg::PIX_W-1:0]  in_pix,
	input  wire bad_pkg::ctl_t              in_ctl,
	output logic                            push,
	output bad_pkg::rec_t                   push_rec,
	output logic [1:0]                      inflight
);

	// stage 1: read data back, add, write back
	logic                      v_s1;
	bad_pkg::ctl_t             ctl_s1;
	logic [AW-1:0]             addr_s1;
	logic [bad_pkg::PIX_W-1:0] pix_s1;
	logic                      fwd_s1;
	logic [SUM_W-1:0]          fwd_data_s1;
	logic [SUM_W-1:0]          rd_data;
	logic [SUM_W-1:0]          base;
	logic [SUM_W-1:0]          sum;
	logic [DEPTH-1:0]          valid_q;
	logic                      wr_en;

	// stage 2: quantize
	logic             v_s2;
	bad_pkg::ctl_t    ctl_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [3:0]       idx;

	bad_acc_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (SUM_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (in_valid && in_ctl.in_range),
		.rd_addr (in_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (sum)
	);

	// write lands on the edge the next item reads: forward it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			fwd_s1 <= in_valid && v_s1 && ctl_s1.in_range && !ctl_s1.frame_end
				&& (addr_s1 == in_addr);
			v_s2   <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1      <= in_ctl;
		addr_s1     <= in_addr;
		pix_s1      <= in_pix;
		fwd_data_s1 <= ctl_s1.blk_done ? '0 : sum;
		ctl_s2      <= ctl_s1;
		sum_s2      <= sum;
	end

	assign base  = fwd_s1 ? fwd_data_s1 : (valid_q[addr_s1] ? rd_data : '0);
	assign sum   = base + SUM_W'(pix_s1);
	assign wr_en = v_s1 && ctl_s1.in_range && !ctl_s1.blk_done;

	// entry valid bits; a finished block or a frame end reads back as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (v_s1 && ctl_s1.frame_end) begin
			valid_q <= '0;
		end else if (v_s1 && ctl_s1.in_range) begin
			valid_q[addr_s1] <= !ctl_s1.blk_done;
		end
	end

	always_comb begin
		idx = '0;
		for (int k = 1; k <= bad_pkg::RAMP_TOP; k++) begin
			if (int'(sum_s2) >= bad_pkg::level_threshold(k, BLOCK_AREA)) begin
				idx = 4'(k);
			end
		end
	end

	assign push = v_s2 && (ctl_s2.blk_done || ctl_s2.has_nl || ctl_s2.frame_end);

	always_comb begin
		push_rec.char_code = bad_pkg::ramp_char(idx);
		push_rec.has_blk   = ctl_s2.blk_done;
		push_rec.has_nl    = ctl_s2.has_nl;
		push_rec.has_eof   = ctl_s2.frame_end;
		push_rec.side      = ctl_s2.side;
	end

	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};

endmodule
`default_nettype wire

/* rtl/core/bad_out_queue.sv */
`default_nettype none
module bad_out_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire bad_pkg::rec_t               push_rec,
	output logic [bad_pkg::LVL_W-1:0]        level,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [bad_pkg::CHAR_W-1:0]       out_char,
	output logic                             out_eol,
	output logic                             out_eof,
	output logic                             out_side,
	output logic                             out_last
);

	bad_pkg::rec_t               fifo_q [bad_pkg::OQ_DEPTH];
	logic [bad_pkg::OQ_AW-1:0]   wr_ptr_q;
	logic [bad_pkg::OQ_AW-1:0]   rd_ptr_q;
	logic [bad_pkg::LVL_W-1:0]   count_q;
	bad_pkg::rec_t               cur_q;
	logic [2:0]                  rem_q;   // {eof, newline, block char} still to send
	logic [2:0]                  sel;
	logic                        pop;

	assign sel       = rem_q & (~rem_q + 3'd1);
	assign out_valid = |rem_q;
	assign out_last  = (rem_q & ~sel) == 3'b000;
	assign pop       = (count_q != '0) && (!out_valid || (out_ready && out_last));
	assign level     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_rec;
		end
		if (pop) begin
			cur_q <= fifo_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			rem_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				rem_q    <= {fifo_q[rd_ptr_q].has_eof, fifo_q[rd_ptr_q].has_nl,
					fifo_q[rd_ptr_q].has_blk};
			end else if (out_valid && out_ready) begin
				rem_q <= rem_q & ~sel;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_comb begin
		out_eol  = 1'b0;
		out_eof  = 1'b0;
		out_side = cur_q.side;
		case (sel)
			3'b001: out_char = cur_q.char_code;
			3'b010: begin
				out_char = bad_pkg::CHAR_NEWLINE;
				out_eol  = 1'b1;
			end
			3'b100: begin
				out_char = bad_pkg::CHAR_NUL;
				out_eof  = 1'b1;
			end
			default: out_char = bad_pkg::CHAR_NUL;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/block_average_ascii_downscaler.sv */
// A pixel's result passes both accumulator stages and the result queue. Throughput: one
// pixel and one result per cycle unless m_axis stalls; s_axis_tready drops once queued
// result groups plus pixels in the two accumulator stages reach the 4-entry queue depth.
// Reset (arst_n, async, active low): counters at start, all column sums read as zero,
// frame_width 640, frame_height 480. No clearing pass; entry valid bits clear at once.
`default_nettype none
module block_average_ascii_downscaler #(
	parameter int BLOCK_COLS = bad_pkg::BLOCK_COLS_DEF,
	parameter int BLOCK_ROWS = bad_pkg::BLOCK_ROWS_DEF,
	parameter int MAX_WIDTH  = bad_pkg::MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// pixel items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
	input  wire logic [0:0]  s_axis_tuser,   // [0] camera_side
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // [6:0] char_code, [7] zero
	output logic [2:0]       m_axis_tuser,   // [0] end_of_line, [1] end_of_frame,
	                                         // [2] camera_side_out
	output logic             m_axis_tlast    // last_of_run
);

	localparam int NUM_ACC   = MAX_WIDTH / BLOCK_COLS;
	localparam int ACC_DEPTH = (NUM_ACC > 0) ? NUM_ACC : 1;
	localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int SUM_W     = $clog2(BLOCK_COLS * BLOCK_ROWS * 255 + 1);
	localparam int CSUB_W    = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;
	localparam int RSUB_W    = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
	localparam int FW_W      = bad_pkg::FW_W;
	localparam int FH_W      = bad_pkg::FH_W;
	localparam int BLAST_W   = FW_W + 1;

	// ---------------- configuration registers ----------------
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bad_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bad_pkg::FRAME_HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				bad_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				bad_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bad_pkg::REG_FRAME_WIDTH:  prdata = {{(32-FW_W){1'b0}}, frame_width_q};
			bad_pkg::REG_FRAME_HEIGHT: prdata = {{(32-FH_W){1'b0}}, frame_height_q};
			default:                   prdata = '0;
		endcase
	end

	// ---------------- raster position ----------------
	// All positions are kept as incremental counters so no divide is needed:
	// csub = column within block, bcol = block column, blast = last pixel
	// column of the current block, rsub = row within block row.
	logic [FW_W-1:0]    pcol_q;
	logic [FH_W-1:0]    prow_q;
	logic [CSUB_W-1:0]  csub_q;
	logic [FW_W-1:0]    bcol_q;
	logic [BLAST_W-1:0] blast_q;
	logic [RSUB_W-1:0]  rsub_q;

	logic [FW_W-1:0] w_eff;
	logic [FH_W-1:0] h_eff;
	logic            accept;
	logic            row_end;
	logic            frame_end;
	logic            block_row_end;
	logic            block_col_end;
	logic            in_range;
	logic            last_blk;
	logic            no_blocks;
	bad_pkg::ctl_t   ctl;

	// zero width or height behaves as one
	assign w_eff = (frame_width_q == '0)  ? FW_W'(1) : frame_width_q;
	assign h_eff = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;

	assign row_end       = ({1'b0, pcol_q} + 1'b1) >= {1'b0, w_eff};
	assign frame_end     = row_end && (({1'b0, prow_q} + 1'b1) >= {1'b0, h_eff});
	assign block_row_end = rsub_q == RSUB_W'(BLOCK_ROWS - 1);
	assign block_col_end = csub_q == CSUB_W'(BLOCK_COLS - 1);

	// pixel belongs to a whole block column that has an accumulator
	assign in_range  = (blast_q < {1'b0, w_eff}) && (int'(bcol_q) < NUM_ACC);
	// next block column is partial or beyond the accumulators
	assign last_blk  = ((blast_q + BLAST_W'(BLOCK_COLS)) >= {1'b0, w_eff})
		|| (int'(bcol_q) == NUM_ACC - 1);
	// frame narrower than one block: newline rides on the row end alone
	assign no_blocks = ({1'b0, w_eff} < BLAST_W'(BLOCK_COLS)) || (NUM_ACC == 0);

	always_comb begin
		ctl.in_range  = in_range;
		ctl.blk_done  = in_range && block_col_end && block_row_end;
		ctl.has_nl    = (in_range && block_col_end && block_row_end && last_blk)
			|| (no_blocks && row_end && block_row_end);
		ctl.frame_end = frame_end;
		ctl.side      = s_axis_tuser[0];
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q  <= '0;
			prow_q  <= '0;
			csub_q  <= '0;
			bcol_q  <= '0;
			blast_q <= BLAST_W'(BLOCK_COLS - 1);
			rsub_q  <= '0;
		end else if (accept) begin
			if (row_end) begin
				pcol_q  <= '0;
				csub_q  <= '0;
				bcol_q  <= '0;
				blast_q <= BLAST_W'(BLOCK_COLS - 1);
				if (frame_end) begin
					prow_q <= '0;
					rsub_q <= '0;
				end else begin
					prow_q <= prow_q + 1'b1;
					rsub_q <= block_row_end ? '0 : rsub_q + 1'b1;
				end
			end else begin
				pcol_q <= pcol_q + 1'b1;
				if (block_col_end) begin
					csub_q  <= '0;
					bcol_q  <= bcol_q + 1'b1;
					blast_q <= blast_q + BLAST_W'(BLOCK_COLS);
				end else begin
					csub_q <= csub_q + 1'b1;
				end
			end
		end
	end

	// ---------------- accumulators and result queue ----------------
	logic                      push;
	bad_pkg::rec_t             push_rec;
	logic [1:0]                inflight;
	logic [bad_pkg::LVL_W-1:0] level;
	logic [bad_pkg::CHAR_W-1:0] out_char;
	logic                      out_eol;
	logic                      out_eof;
	logic                      out_side;
	logic                      out_last;

	// credit: every item in flight may still need one queue entry
	assign s_axis_tready = (int'(level) + int'(inflight)) < bad_pkg::OQ_DEPTH;

	bad_accum #(
		.BLOCK_AREA (BLOCK_COLS * BLOCK_ROWS),
		.DEPTH      (ACC_DEPTH),
		.AW         (ACC_AW),
		.SUM_W      (SUM_W)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_addr  (ACC_AW'(bcol_q)),
		.in_pix   (s_axis_tdata),
		.in_ctl   (ctl),
		.push     (push),
		.push_rec (push_rec),
		.inflight (inflight)
	);

	bad_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.level     (level),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_eol   (out_eol),
		.out_eof   (out_eof),
		.out_side  (out_side),
		.out_last  (out_last)
	);

	assign m_axis_tdata = {1'b0, out_char};
	assign m_axis_tuser = {out_side, out_eof, out_eol};
	assign m_axis_tlast = out_last;

endmodule
`default_nettype wire

/* sim/block_average_ascii_downscaler_tb.sv */
`default_nettype none
module block_average_ascii_downscaler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// geometry of the block as built (default parameters)
	localparam int BLOCK_COLS = bad_pkg::BLOCK_COLS_DEF;
	localparam int BLOCK_ROWS = bad_pkg::BLOCK_ROWS_DEF;
	localparam int NUM_BLK    = bad_pkg::MAX_WIDTH_DEF / bad_pkg::BLOCK_COLS_DEF;
	localparam int AREA       = BLOCK_COLS * BLOCK_ROWS;
	localparam int PIX_MAX    = (1 << bad_pkg::PIX_W) - 1;
	localparam int RAMP_TOP   = bad_pkg::RAMP_TOP;
	localparam int CHAR_W     = bad_pkg::CHAR_W;
	localparam int FW_W       = bad_pkg::FW_W;
	localparam int FH_W       = bad_pkg::FH_W;

	// brightness ramp, darkest first; char k sits at bits [8*(9-k) +: 8]
	localparam logic [79:0] RAMP = " .:-=+*#%@";

	// generous: ~1k pixels, worst gaps and stalls fit many times over
	localparam int CYCLE_LIMIT   = 400_000;
	// cycles to let the pipeline settle after the last expected char
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_PIXELS = 100;
	localparam int RANDOM_CHARS  = 20;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              eol;
		logic              eof;
		logic              side;
		logic              last;
	} char_item_t;

	// DUT ports, all inputs known from time zero
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata = '0;   // [7:0] pixel_value
	logic [0:0]        s_axis_tuser = '0;   // [0] camera_side
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;        // [6:0] char_code, [7] zero
	logic [2:0]        m_axis_tuser;        // [0] end_of_line, [1] end_of_frame,
	                                        // [2] camera_side_out
	logic              m_axis_tlast;        // last_of_run

	// predictor state: our own copy of registers, counters and block sums
	logic [FW_W-1:0]   width_reg = bad_pkg::FRAME_WIDTH_RST;
	logic [FH_W-1:0]   height_reg = bad_pkg::FRAME_HEIGHT_RST;
	logic [FW_W-1:0]   cur_col = '0;
	logic [FH_W-1:0]   cur_row = '0;
	int unsigned       blk_sum [NUM_BLK];

	// chars predicted but not yet seen on m_axis, oldest first
	char_item_t        pending_chars [$];
	char_item_t        want;

	int                errors = 0;
	int                pixels_sent = 0;
	int                chars_seen = 0;
	int                cycle_count = 0;

	// sender burst control
	int                tx_max_gap = 0;
	int                burst_left = 0;

	// receiver stall control: mode 0 always ready, 1 light, 2 heavy;
	// rx_hold forces a long hold-off, counted down in the receiver process
	int                rx_mode = 0;
	int                rx_hold = 0;
	int                rx_run = 0;
	logic              rx_on = 1'b1;

	block_average_ascii_downscaler uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d chars still pending", $time, pending_chars.size());
			$display("block_average_ascii_downscaler: mismatch");
			$finish;
		end
	end

	// receiver: forced hold-off first, else alternating ready/stall runs
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			m_axis_tready = 1'b0;
			rx_hold = rx_hold - 1;
		end else if (rx_mode == 0) begin
			m_axis_tready = 1'b1;
		end else begin
			if (rx_run == 0) begin
				rx_on = !rx_on;
				rx_run = rx_on ? $urandom_range(1, 12) :
					$urandom_range(1, (rx_mode == 2) ? 12 : 3);
			end
			m_axis_tready = rx_on;
			rx_run = rx_run - 1;
		end
	end

	function automatic logic [7:0] rand_pix();
		return 8'($urandom_range(0, PIX_MAX));
	endfunction

	function automatic logic rand_side();
		return 1'($urandom_range(0, 1));
	endfunction

	// ramp char for one finished block sum
	function automatic logic [CHAR_W-1:0] level_char(input int unsigned sum);
		int unsigned idx;
		idx = ((sum / AREA) * RAMP_TOP) / PIX_MAX;
		if (idx > RAMP_TOP)
			idx = RAMP_TOP;
		return RAMP[8 * (RAMP_TOP - idx) +: CHAR_W];
	endfunction

	// Advance the predictor by one accepted pixel and queue its chars:
	// block char, then row newline, then frame terminator.
	task automatic downscale_pixel(input logic [7:0] pix, input logic side);
		int unsigned w, h, nblk, bcol;
		bit          brow_end, row_end, frm_end;
		char_item_t  res [3];
		int          n;
		n = 0;
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		nblk = w / BLOCK_COLS;
		if (nblk > NUM_BLK)
			nblk = NUM_BLK;
		bcol = cur_col / BLOCK_COLS;
		brow_end = (cur_row % BLOCK_ROWS) == BLOCK_ROWS - 1;
		row_end = cur_col + 1 >= w;
		frm_end = row_end && (cur_row + 1 >= h);

		if (bcol < nblk) begin
			blk_sum[bcol] += pix;
			if ((cur_col % BLOCK_COLS) == BLOCK_COLS - 1 && brow_end) begin
				res[n] = '{level_char(blk_sum[bcol]), 1'b0, 1'b0, side, 1'b0};
				n++;
				blk_sum[bcol] = 0;
				if (bcol + 1 == nblk) begin
					res[n] = '{bad_pkg::CHAR_NEWLINE, 1'b1, 1'b0, side, 1'b0};
					n++;
				end
			end
		end else if (nblk == 0 && row_end && brow_end) begin
			// no whole block column: newline still closes the block row
			res[n] = '{bad_pkg::CHAR_NEWLINE, 1'b1, 1'b0, side, 1'b0};
			n++;
		end

		if (frm_end) begin
			res[n] = '{bad_pkg::CHAR_NUL, 1'b0, 1'b1, side, 1'b0};
			n++;
			foreach (blk_sum[i])
				blk_sum[i] = 0;
			cur_col = '0;
			cur_row = '0;
		end else if (row_end) begin
			cur_col = '0;
			cur_row = cur_row + 1'b1;
		end else begin
			cur_col = cur_col + 1'b1;
		end

		for (int i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			pending_chars.push_back(res[i]);
		end
	endtask

	// one pixel over s_axis; random gaps open each new burst
	task automatic send_pixel(input logic [7:0] pix, input logic side);
		int gap;
		if (burst_left == 0) begin
			gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
			burst_left = $urandom_range(1, 20);
			repeat (gap) @(negedge clk) s_axis_tvalid = 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = pix;
		s_axis_tuser = side;
		do @(posedge clk); while (!s_axis_tready);
		downscale_pixel(pix, side);
		pixels_sent++;
		burst_left--;
	endtask

	// stop sending and wait for every expected char, then let the pipe settle
	task automatic drain_chars();
		@(negedge clk) s_axis_tvalid = 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup, then access; taken at the edge with pready high
	task automatic write_reg(input logic idx, input int unsigned value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk) penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == bad_pkg::REG_FRAME_WIDTH)
			width_reg = value[FW_W-1:0];
		else
			height_reg = value[FH_W-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		drain_chars();
		write_reg(bad_pkg::REG_FRAME_WIDTH, w);
		write_reg(bad_pkg::REG_FRAME_HEIGHT, h);
	endtask

	task automatic report_field(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		errors++;
		$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
	endtask

	// result checker: every accepted char against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected char, expected none, got tdata=%0d tuser=%b tlast=%b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== {1'b0, want.code})
					report_field("char_code", want.code, m_axis_tdata);
				if (m_axis_tuser[0] !== want.eol)
					report_field("end_of_line", want.eol, m_axis_tuser[0]);
				if (m_axis_tuser[1] !== want.eof)
					report_field("end_of_frame", want.eof, m_axis_tuser[1]);
				if (m_axis_tuser[2] !== want.side)
					report_field("camera_side_out", want.side, m_axis_tuser[2]);
				if (m_axis_tlast !== want.last)
					report_field("last_of_run", want.last, m_axis_tlast);
			end
		end
	end

	// a few pixels under the reset geometry (640x480): no chars yet
	task automatic test_reset_defaults();
		tx_max_gap = 3;
		rx_mode = 1;
		repeat (8) send_pixel(rand_pix(), rand_side());
	endtask

	// zero size acts as one; narrower than a block gives bare newlines
	task automatic test_degenerate_sizes();
		set_frame(0, 0);
		repeat (3) send_pixel(rand_pix(), rand_side());
		set_frame(3, BLOCK_ROWS);
		repeat (3 * BLOCK_ROWS) send_pixel(rand_pix(), rand_side());
	endtask

	// all-ones registers, then shrink both mid-frame so the row ends at once
	task automatic test_extreme_registers();
		set_frame(2047, 1023);
		repeat (12) send_pixel(rand_pix(), rand_side());
		set_frame(2, 1);
		repeat (3) send_pixel(rand_pix(), rand_side());
	endtask

	// width cut below the current column mid-row, then height cut below row
	task automatic test_mid_frame_write();
		set_frame(20, 40);
		repeat (15) send_pixel(rand_pix(), rand_side());
		drain_chars();
		write_reg(bad_pkg::REG_FRAME_WIDTH, 12);
		// column 15 is past the new width: row 0 ends here
		send_pixel(rand_pix(), rand_side());
		drain_chars();
		write_reg(bad_pkg::REG_FRAME_HEIGHT, 1);
		// row 1 is past the new height: its row end closes the frame
		repeat (12) send_pixel(rand_pix(), rand_side());
	endtask

	// one block sits exactly on the threshold of a random ramp level, or one
	// pixel below it; a leftover column and a cut last block row are ignored
	task automatic test_ramp_levels();
		int  k, v;
		bit  below;
		k = $urandom_range(1, RAMP_TOP);
		below = 1'($urandom_range(0, 1));
		set_frame(BLOCK_COLS + 1, BLOCK_ROWS + 1);
		for (int r = 0; r < BLOCK_ROWS + 1; r++) begin
			for (int c = 0; c < BLOCK_COLS + 1; c++) begin
				if (r < BLOCK_ROWS && c < BLOCK_COLS) begin
					v = (PIX_MAX * k + RAMP_TOP - 1) / RAMP_TOP;
					if (below && r == 0 && c == 0)
						v = v - 1;
					send_pixel(v[7:0], r[0]);
				end else begin
					send_pixel(rand_pix(), rand_side());
				end
			end
		end
	endtask

	// 1x1 frames: one terminator per pixel; long receiver hold-off fills the
	// result queue while the sender keeps offering
	task automatic test_back_pressure();
		set_frame(1, 1);
		tx_max_gap = 0;
		rx_mode = 0;
		@(posedge clk) rx_hold = 80;
		repeat (40) send_pixel(rand_pix(), rand_side());
		drain_chars();
	endtask

	// random whole frames with random geometry, brightness and idling
	task automatic test_random_frames();
		int unsigned w, h, sel, nframes, lo, hi, n_pix;
		int          start_pixels, start_chars;
		bit          tall;
		start_pixels = pixels_sent;
		start_chars = chars_seen;
		while (pixels_sent - start_pixels < RANDOM_PIXELS ||
			chars_seen - start_chars < RANDOM_CHARS) begin
			sel = $urandom_range(0, 9);
			tall = ($urandom_range(0, 2) == 0);
			if (tall)
				h = $urandom_range(BLOCK_ROWS - 1, BLOCK_ROWS + 2);
			else
				h = $urandom_range(0, 3);
			if (sel < 6)
				w = $urandom_range(BLOCK_COLS, 2 * BLOCK_COLS);
			else if (sel < 8 || tall)
				w = $urandom_range(0, BLOCK_COLS - 1);
			else
				w = $urandom_range(2 * BLOCK_COLS + 1, 3 * BLOCK_COLS);
			nframes = tall ? 1 : $urandom_range(1, 4);
			set_frame(w, h);
			sel = $urandom_range(0, 2);
			tx_max_gap = (sel == 0) ? 0 : (sel == 1) ? 2 : 8;
			rx_mode = $urandom_range(0, 2);
			n_pix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * nframes;
			lo = $urandom_range(0, PIX_MAX);
			hi = $urandom_range(lo, PIX_MAX);
			repeat (n_pix) send_pixel(8'($urandom_range(lo, hi)), rand_side());
		end
	endtask

	initial begin
		foreach (blk_sum[i])
			blk_sum[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_reset_defaults();
		test_degenerate_sizes();
		test_extreme_registers();
		test_mid_frame_write();
		test_ramp_levels();
		test_back_pressure();
		test_random_frames();

		// wait out the tail; stray chars after this still count as errors
		drain_chars();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d pixels and %0d chars: zero, narrow and all-ones sizes,",
			pixels_sent, chars_seen);
		$display("mid-frame resizes, a ramp threshold, cut blocks, long stalls, random frames");
		if (errors == 0)
			$display("block_average_ascii_downscaler: match");
		else
			$display("block_average_ascii_downscaler: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
